@@ rtl/spq_pkg.sv @@
// Package: shared constants, command codes and cell control type of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT  = 8;
   localparam int CAP_BITS         = 5;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } spq_cmd_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic push;
      logic pop;
   } spq_cell_ctl_type;

endpackage

@@ rtl/spq_channels.sv @@
// Interfaces: request and response channels of the sorted priority queue.
`timescale 1ns / 1ps
interface spq_req_if #(
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic                command;
   logic [KEY_BITS-1:0] key;
   logic [ID_BITS-1:0]  item_id;

   modport source (output valid, command, key, item_id, input ready);
   modport sink   (input valid, command, key, item_id, output ready);
endinterface

interface spq_rsp_if #(
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEFAULT,
   parameter int CNT_BITS = $clog2(spq_pkg::DEPTH_DEFAULT + 1)
);
   logic                valid;
   logic                ready;
   logic                out_valid;
   logic [KEY_BITS-1:0] out_key;
   logic [ID_BITS-1:0]  out_id;
   logic                was_dropped;
   logic [CNT_BITS-1:0] entries_held;

   modport source (output valid, out_valid, out_key, out_id, was_dropped, entries_held,
                   input ready);
   modport sink   (input valid, out_valid, out_key, out_id, was_dropped, entries_held,
                   output ready);
endinterface

@@ rtl/spq_cell.sv @@
// Module: one storage cell of the sorted row, holding one key and identifier.
`timescale 1ns / 1ps
module spq_cell #(
   parameter int IDX      = 0,
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEFAULT,
   parameter int CNT_BITS = $clog2(spq_pkg::DEPTH_DEFAULT + 1)
) (
   input  logic                      clock,
   input  spq_pkg::spq_cell_ctl_type ctl,
   input  logic [CNT_BITS-1:0]       count,
   input  logic [KEY_BITS-1:0]       new_key,
   input  logic [ID_BITS-1:0]        new_id,
   input  logic                      prev_ins,
   input  logic [KEY_BITS-1:0]       prev_key,
   input  logic [ID_BITS-1:0]        prev_id,
   input  logic [KEY_BITS-1:0]       next_key,
   input  logic [ID_BITS-1:0]        next_id,
   output logic                      ins,
   output logic [KEY_BITS-1:0]       key,
   output logic [ID_BITS-1:0]        id
);
   import spq_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic                occupied;

   assign occupied = CNT_BITS'(IDX) < count;
   // true from the insertion point on: empty, or holds a strictly larger key
   assign ins      = !occupied || (key_ff > new_key);

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (ctl.push) begin
         if (prev_ins) begin
            key_in = prev_key;
            id_in  = prev_id;
         end else if (ins) begin
            key_in = new_key;
            id_in  = new_id;
         end
      end else if (ctl.pop) begin
         key_in = next_key;
         id_in  = next_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key = key_ff;
   assign id  = id_ff;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// Top level: sorted-array min-priority queue built as a row of shifting cells.
//
//   port group   dir   handshake        carries
//   req_if       in    valid / ready    command, key, item_id
//   rsp_if       out   valid / ready    out_valid, out_key, out_id, was_dropped, entries_held
//   csr_*        in    csr_wr_en        csr_wr_data (capacity)
//
// Every cell compares its key to the new key at once and the whole row shifts in the
// same edge, so one request is accepted per cycle while the response slot is not stalled.
// The response is registered; a stalled response holds the request side only until
// it is taken (ready = response slot empty or being drained).
// Synchronous active-high reset empties the queue, clears the response slot and
// restores the capacity to the built depth. Storage needs no clearing pass.
`timescale 1ns / 1ps
module sorted_priority_queue_core #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   spq_req_if.sink                      req_if,
   spq_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [spq_pkg::CAP_BITS-1:0] csr_wr_data
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   // capacity register; cap_full_ff marks "limit is the built depth" after reset
   logic [CAP_BITS-1:0] cap_ff;
   logic                cap_full_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // response slot
   logic                rsp_valid_ff;
   logic                out_valid_ff, out_valid_in;
   logic [KEY_BITS-1:0] out_key_ff, out_key_in;
   logic [ID_BITS-1:0]  out_id_ff, out_id_in;
   logic                dropped_ff, dropped_in;
   logic [CNT_BITS-1:0] held_ff;

   logic             accept;
   logic             has_room;
   logic             not_empty;
   spq_cell_ctl_type ctl;

   logic [KEY_BITS-1:0] cell_key [DEPTH];
   logic [ID_BITS-1:0]  cell_id  [DEPTH];
   logic                cell_ins [DEPTH];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign not_empty = count_ff != '0;
   assign has_room  = (count_ff < CNT_BITS'(DEPTH)) &&
                      (cap_full_ff || (CMP_BITS'(count_ff) < CMP_BITS'(cap_ff)));

   always_comb begin
      ctl.push     = 1'b0;
      ctl.pop      = 1'b0;
      count_in     = count_ff;
      out_valid_in = 1'b0;
      out_key_in   = '0;
      out_id_in    = '0;
      dropped_in   = 1'b0;
      if (accept) begin
         case (spq_cmd_type'(req_if.command))
            CMD_PUSH: begin
               if (has_room) begin
                  ctl.push = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            CMD_POP: begin
               if (not_empty) begin
                  ctl.pop      = 1'b1;
                  count_in     = count_ff - 1'b1;
                  out_valid_in = 1'b1;
                  out_key_in   = cell_key[0];
                  out_id_in    = cell_id[0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // row of cells: push opens a gap at the first larger key, pop shifts toward the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                p_ins;
      logic [KEY_BITS-1:0] p_key, n_key;
      logic [ID_BITS-1:0]  p_id, n_id;

      if (i == 0) begin : g_head
         assign p_ins = 1'b0;
         assign p_key = req_if.key;
         assign p_id  = req_if.item_id;
      end else begin : g_body
         assign p_ins = cell_ins[i-1];
         assign p_key = cell_key[i-1];
         assign p_id  = cell_id[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_key = cell_key[i];
         assign n_id  = cell_id[i];
      end else begin : g_inner
         assign n_key = cell_key[i+1];
         assign n_id  = cell_id[i+1];
      end

      spq_cell #(
         .IDX      (i),
         .KEY_BITS (KEY_BITS),
         .ID_BITS  (ID_BITS),
         .CNT_BITS (CNT_BITS)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count_ff),
         .new_key  (req_if.key),
         .new_id   (req_if.item_id),
         .prev_ins (p_ins),
         .prev_key (p_key),
         .prev_id  (p_id),
         .next_key (n_key),
         .next_id  (n_id),
         .ins      (cell_ins[i]),
         .key      (cell_key[i]),
         .id       (cell_id[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= '0;
         cap_full_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff      <= csr_wr_data;
            cap_full_ff <= 1'b0;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         out_valid_ff <= out_valid_in;
         out_key_ff   <= out_key_in;
         out_id_ff    <= out_id_in;
         dropped_ff   <= dropped_in;
         held_ff      <= count_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_valid    = out_valid_ff;
   assign rsp_if.out_key      = out_key_ff;
   assign rsp_if.out_id       = out_id_ff;
   assign rsp_if.was_dropped  = dropped_ff;
   assign rsp_if.entries_held = held_ff;

endmodule

@@ rtl/spq_checker.sv @@
// Checker: port-level assertions on the response side, bound to the queue top level.
`timescale 1ns / 1ps
module spq_checker #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEFAULT,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEFAULT,
   parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                out_valid,
   input logic [KEY_BITS-1:0] out_key,
   input logic [ID_BITS-1:0]  out_id,
   input logic                was_dropped,
   input logic [CNT_BITS-1:0] entries_held
);
   import spq_pkg::*;

   // a dropped push never carries a popped entry
   a_drop_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(was_dropped && out_valid))
      else $error("dropped push reported a popped entry");

   // empty pop and push results carry zero payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !out_valid) |-> (out_key == '0 && out_id == '0))
      else $error("nonzero key or id without a popped entry");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (entries_held <= CNT_BITS'(DEPTH)))
      else $error("entries_held beyond built depth");

   // a pop that returned an entry always leaves at least one free slot
   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_valid) |-> (entries_held < CNT_BITS'(DEPTH)))
      else $error("popped entry but queue still reported full");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_key) && $stable(out_id)
                                     && $stable(entries_held)))
      else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker #(
   .DEPTH    (DEPTH),
   .KEY_BITS (KEY_BITS),
   .ID_BITS  (ID_BITS)
) u_spq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .out_valid    (rsp_if.out_valid),
   .out_key      (rsp_if.out_key),
   .out_id       (rsp_if.out_id),
   .was_dropped  (rsp_if.was_dropped),
   .entries_held (rsp_if.entries_held)
);

@@ tb/tb_top.sv @@
// Testbench top: sorted priority queue checked against an in-bench shadow queue.
`timescale 1ns / 1ps
module tb_top;
   import spq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int KW    = KEY_BITS_DEFAULT;
   localparam int IW    = ID_BITS_DEFAULT;
   localparam int CW    = CAP_BITS;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 112;
   localparam int DRAIN_LIMIT     = 2000;   // cycles allowed for the last responses
   localparam int RUN_LIMIT_NS    = 10_000_000;

   // one response as it leaves the block
   typedef struct packed {
      logic          out_valid;
      logic [KW-1:0] out_key;
      logic [IW-1:0] out_id;
      logic          was_dropped;
      logic [CW-1:0] entries_held;
   } spq_result_type;

   // directed step: either a capacity write or a request, with an optional
   // hand-written response (zero when the shadow queue decides it)
   typedef struct {
      bit             is_csr;
      logic [CW-1:0]  csr_value;
      spq_cmd_type    cmd;
      logic [KW-1:0]  key;
      logic [IW-1:0]  id;
      bit             use_fixed;
      spq_result_type fixed;
   } directed_step_type;

   logic clock;
   logic reset;
   logic          csr_wr_en;
   logic [CW-1:0] csr_wr_data;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the queue: sorted, smallest key at slot 0
   logic [KW-1:0] shadow_keys [DEPTH];
   logic [IW-1:0] shadow_ids  [DEPTH];
   int unsigned   shadow_count;
   logic [CW-1:0] shadow_capacity;

   spq_result_type expected_responses [$];

   int src_gap_max;
   int sink_gap_max;
   int requests_sent;
   int pops_returned;
   int pushes_dropped;
   int capacity_writes;
   int mismatches;

   int phase_capacity [PHASES] = '{16, 31, 1, 4, 0, 16, 2, 16, 9, 31, 16, 3};
   // push-heavy phases fill the queue; the one after may drop the capacity under it
   int phase_push_pct [PHASES] = '{50, 80, 50, 80, 50, 80, 50, 80, 25, 80, 80, 25};
   int gap_levels     [3]      = '{0, 16, 3};

   directed_step_type directed_steps [0:28] = '{
      // empty after reset
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd0}},
      // key extremes, then equal keys (must leave in arrival order)
      '{0, 0,  CMD_PUSH, 16'hFFFF, 8'hFF, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd1}},
      '{0, 0,  CMD_PUSH, 16'h0000, 8'h00, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd2}},
      '{0, 0,  CMD_PUSH, 16'h8000, 8'h55, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h8000, 8'hAA, 0, '0},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 1, '{1'b1, 16'h0000, 8'h00, 1'b0, 5'd3}},
      '{0, 0,  CMD_POP,  16'hFFFF, 8'hFF, 0, '0},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 1, '{1'b1, 16'hFFFF, 8'hFF, 1'b0, 5'd0}},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd0}},
      // capacity one: second push finds it full
      '{1, 1,  CMD_PUSH, 16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h1234, 8'h01, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd1}},
      '{0, 0,  CMD_PUSH, 16'h0001, 8'h02, 1, '{1'b0, 16'h0000, 8'h00, 1'b1, 5'd1}},
      // capacity zero: pushes dropped, pops still drain
      '{1, 0,  CMD_PUSH, 16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0000, 8'h03, 1, '{1'b0, 16'h0000, 8'h00, 1'b1, 5'd1}},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      // capacity above depth saturates
      '{1, 31, CMD_PUSH, 16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0005, 8'h04, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0005, 8'h05, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0002, 8'h06, 0, '0},
      // capacity lowered under the held count: entries kept, pushes dropped
      '{1, 1,  CMD_PUSH, 16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0000, 8'h07, 1, '{1'b0, 16'h0000, 8'h00, 1'b1, 5'd3}},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0003, 8'h08, 1, '{1'b0, 16'h0000, 8'h00, 1'b1, 5'd1}},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      '{0, 0,  CMD_PUSH, 16'h0009, 8'h09, 1, '{1'b0, 16'h0000, 8'h00, 1'b0, 5'd1}},
      '{0, 0,  CMD_POP,  16'h0000, 8'h00, 0, '0},
      '{1, 16, CMD_PUSH, 16'h0000, 8'h00, 0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   // Shadow queue update for one request; returns the response it must produce.
   // Push: insert behind every key that is equal or smaller (stable order).
   // Pop: take slot 0, shift the rest forward.
   function automatic spq_result_type predict_queue_op(input spq_cmd_type cmd,
                                                       input logic [KW-1:0] key,
                                                       input logic [IW-1:0] id);
      spq_result_type r;
      int unsigned    room;
      int unsigned    slot;
      r    = '0;
      room = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
      if (cmd == CMD_PUSH) begin
         if (shadow_count < room) begin
            slot = shadow_count;
            while (slot > 0 && shadow_keys[slot-1] > key) begin
               shadow_keys[slot] = shadow_keys[slot-1];
               shadow_ids[slot]  = shadow_ids[slot-1];
               slot--;
            end
            shadow_keys[slot] = key;
            shadow_ids[slot]  = id;
            shadow_count++;
         end else begin
            r.was_dropped = 1'b1;
         end
      end else if (shadow_count > 0) begin
         r.out_valid = 1'b1;
         r.out_key   = shadow_keys[0];
         r.out_id    = shadow_ids[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_ids[i-1]  = shadow_ids[i];
         end
         shadow_count--;
      end
      // empty pop falls through with all zeros and the count unchanged
      r.entries_held = CW'(shadow_count);
      return r;
   endfunction

   // Present one request after a random gap; returns at the accepting edge.
   // Valid is left high so a back-to-back request needs no low pulse.
   task automatic drive_request(input spq_cmd_type cmd, input logic [KW-1:0] key,
                                input logic [IW-1:0] id, input bit use_fixed,
                                input spq_result_type fixed);
      int             gap;
      spq_result_type predicted;
      gap = $urandom_range(0, src_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         // junk payload while idle; must not be taken
         req_ch.valid   <= 1'b0;
         req_ch.command <= spq_cmd_type'($urandom_range(0, 1));
         req_ch.key     <= KW'($urandom);
         req_ch.item_id <= IW'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.key     <= key;
      req_ch.item_id <= id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_queue_op(cmd, key, id);
      expected_responses.push_back(use_fixed ? fixed : predicted);
      requests_sent++;
   endtask

   // Capacity write, only once the queue side has gone quiet.
   task automatic set_capacity(input logic [CW-1:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_responses.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en       <= 1'b0;
      shadow_capacity = value;
      capacity_writes++;
   endtask

   // Response side: random stall before each response, then compare field by field.
   initial begin : response_monitor
      int             stall;
      spq_result_type got;
      spq_result_type want;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, sink_gap_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got = '{rsp_ch.out_valid, rsp_ch.out_key, rsp_ch.out_id,
                 rsp_ch.was_dropped, rsp_ch.entries_held};
         if (got.out_valid)   pops_returned++;
         if (got.was_dropped) pushes_dropped++;
         if (expected_responses.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected, expected nothing, got %p",
                     $time, got);
         end else begin
            want = expected_responses.pop_front();
            if (got.out_valid !== want.out_valid) begin
               mismatches++;
               $display("%0t: out_valid expected %0b got %0b",
                        $time, want.out_valid, got.out_valid);
            end
            if (got.out_key !== want.out_key) begin
               mismatches++;
               $display("%0t: out_key expected %h got %h", $time, want.out_key, got.out_key);
            end
            if (got.out_id !== want.out_id) begin
               mismatches++;
               $display("%0t: out_id expected %h got %h", $time, want.out_id, got.out_id);
            end
            if (got.was_dropped !== want.was_dropped) begin
               mismatches++;
               $display("%0t: was_dropped expected %0b got %0b",
                        $time, want.was_dropped, got.was_dropped);
            end
            if (got.entries_held !== want.entries_held) begin
               mismatches++;
               $display("%0t: entries_held expected %0d got %0d",
                        $time, want.entries_held, got.entries_held);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      spq_cmd_type   cmd;
      logic [KW-1:0] key;
      int            pick;
      int            drain_cycles;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_PUSH;
      req_ch.key      = '0;
      req_ch.item_id  = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      shadow_count    = 0;
      shadow_capacity = CW'(DEPTH);
      src_gap_max     = 3;
      sink_gap_max    = 3;
      requests_sent   = 0;
      pops_returned   = 0;
      pushes_dropped  = 0;
      capacity_writes = 0;
      mismatches      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed steps
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            set_capacity(directed_steps[i].csr_value);
         end else begin
            drive_request(directed_steps[i].cmd, directed_steps[i].key,
                          directed_steps[i].id, directed_steps[i].use_fixed,
                          directed_steps[i].fixed);
         end
      end

      // random phases: each with its own capacity, push/pop mix and idle pattern;
      // entries carry over, so a lower capacity can land under a full queue
      for (int p = 0; p < PHASES; p++) begin
         set_capacity(CW'(phase_capacity[p]));
         src_gap_max  = gap_levels[p % 3];
         sink_gap_max = gap_levels[(p + p / 3) % 3];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            cmd  = ($urandom_range(0, 99) < phase_push_pct[p]) ? CMD_PUSH : CMD_POP;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               key = KW'($urandom);
            end else if (pick < 9) begin
               key = KW'($urandom_range(0, 7));     // many ties
            end else begin
               key = $urandom_range(0, 1) ? '1 : '0;
            end
            drive_request(cmd, key, IW'($urandom), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      drain_cycles = 0;
      while (expected_responses.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_responses.size() != 0) begin
         mismatches++;
         $display("%0t: %0d responses expected but never seen",
                  $time, expected_responses.size());
      end

      $display("Covered %0d requests under %0d capacity writes (zero, one, full, oversize).",
               requests_sent, capacity_writes);
      $display("Pops returning an entry: %0d, pushes refused on a full queue: %0d.",
               pops_returned, pushes_dropped);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_channels.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
tb/tb_top.sv
